/* rtl/core/tcpq_pkg.sv */
// Shared types for the two-class priority queue: request codes and queue controls.
package tcpq_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctrl_t;

endpackage

/* rtl/core/tcpq_req_if.sv */
// Request channel of the two-class priority queue.
interface tcpq_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic                  low_class;
    logic [DATA_WIDTH-1:0] entry_data;

    modport source (output valid, output kind, output low_class, output entry_data,
                    input ready);
    modport sink   (input valid, input kind, input low_class, input entry_data,
                    output ready);
endinterface

/* rtl/core/tcpq_resp_if.sv */
// Result channel of the two-class priority queue.
interface tcpq_resp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int COUNT_W    = 5,
    parameter int TOTAL_W    = 6
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] head_data;
    logic [DATA_WIDTH-1:0] tail_data;
    logic                  not_empty;
    logic [COUNT_W-1:0]    high_count;
    logic [COUNT_W-1:0]    low_count;
    logic [TOTAL_W-1:0]    total_count;
    logic                  op_error;

    modport source (output valid, output head_data, output tail_data, output not_empty,
                    output high_count, output low_count, output total_count,
                    output op_error, input ready);
    modport sink   (input valid, input head_data, input tail_data, input not_empty,
                    input high_count, input low_count, input total_count,
                    input op_error, output ready);
endinterface

/* rtl/core/tcpq_fifo.sv */
// One class queue: circular store, pointers, fill, and registered head and tail reads.
module tcpq_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_W     = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  tcpq_pkg::queue_ctrl_t  ctrl,
    input  logic [DATA_WIDTH-1:0]  wdata,
    output logic [COUNT_W-1:0]     fill,
    output logic [DATA_WIDTH-1:0]  head_data,
    output logic [DATA_WIDTH-1:0]  tail_data
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      tail_ptr;
    logic [COUNT_W-1:0]    fill_reg, fill_next;
    logic [DATA_WIDTH-1:0] head_reg, tail_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctrl.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end
        else if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
        tail_ptr = (wr_ptr_next == '0) ? LAST_PTR : wr_ptr_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else if (step)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (ctrl.push && !ctrl.clear)
            begin
                mem[wr_ptr_reg] <= wdata;
            end
            if (ctrl.push && !ctrl.clear && rd_ptr_next == wr_ptr_reg)
            begin
                head_reg <= wdata;
            end
            else
            begin
                head_reg <= mem[rd_ptr_next];
            end
            if (ctrl.push && !ctrl.clear)
            begin
                tail_reg <= wdata;
            end
            else
            begin
                tail_reg <= mem[tail_ptr];
            end
        end
    end

    assign fill      = fill_reg;
    assign head_data = head_reg;
    assign tail_data = tail_reg;

endmodule

/* rtl/core/two_class_priority_queue.sv */
// Strict-priority two-class queue: request decode, result register and the two class queues.
// Takes one request (push, pop or clear) per clock while no result waits, and returns one
// result per request: the request is held in the request register, then the queues are
// updated and the result registered. Each class queue is a memory with one write
// port and two registered read ports (head and tail), so every request completes in one
// pass. A waiting result stalls the pipeline; the request register frees itself as soon
// as the result is taken. The result shows the queue state after the request: the head
// comes from the high queue when it holds entries, the tail from the low queue when it
// holds entries, and both read zero when the queues are empty. A push to a full queue,
// a pop with both queues empty or an unused request code leaves the state unchanged and
// raises op_error.
module two_class_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    tcpq_req_if.sink    req,
    tcpq_resp_if.source resp
);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOTAL_W = $clog2(2 * QUEUE_DEPTH + 1);

    logic                  s1_valid_reg, s1_valid_next;
    logic [1:0]            kind_reg;
    logic                  low_class_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  err_reg, err_next;

    logic                  advance;
    logic                  step;
    tcpq_pkg::queue_ctrl_t hi_ctrl, lo_ctrl;
    logic [COUNT_W-1:0]    hi_fill, lo_fill;
    logic [DATA_WIDTH-1:0] hi_head, hi_tail, lo_head, lo_tail;
    logic                  hi_full, lo_full;

    assign advance   = !out_valid_reg || resp.ready;
    assign step      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign hi_full   = (hi_fill == COUNT_W'(QUEUE_DEPTH));
    assign lo_full   = (lo_fill == COUNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        hi_ctrl  = '0;
        lo_ctrl  = '0;
        err_next = 1'b0;
        unique case (tcpq_pkg::kind_t'(kind_reg))
            tcpq_pkg::KIND_PUSH:
            begin
                if (low_class_reg)
                begin
                    lo_ctrl.push = !lo_full;
                    err_next     = lo_full;
                end
                else
                begin
                    hi_ctrl.push = !hi_full;
                    err_next     = hi_full;
                end
            end
            tcpq_pkg::KIND_POP:
            begin
                priority if (hi_fill != '0)
                begin
                    hi_ctrl.pop = 1'b1;
                end
                else if (lo_fill != '0)
                begin
                    lo_ctrl.pop = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            tcpq_pkg::KIND_CLEAR:
            begin
                hi_ctrl.clear = 1'b1;
                lo_ctrl.clear = 1'b1;
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req.valid && req.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg      <= req.kind;
            low_class_reg <= req.low_class;
            data_reg      <= req.entry_data;
        end
        if (step)
        begin
            err_reg <= err_next;
        end
    end

    tcpq_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_W     (COUNT_W)
    ) u_high (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .ctrl      (hi_ctrl),
        .wdata     (data_reg),
        .fill      (hi_fill),
        .head_data (hi_head),
        .tail_data (hi_tail)
    );

    tcpq_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_W     (COUNT_W)
    ) u_low (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .ctrl      (lo_ctrl),
        .wdata     (data_reg),
        .fill      (lo_fill),
        .head_data (lo_head),
        .tail_data (lo_tail)
    );

    assign resp.valid       = out_valid_reg;
    assign resp.op_error    = err_reg;
    assign resp.high_count  = hi_fill;
    assign resp.low_count   = lo_fill;
    assign resp.total_count = TOTAL_W'(hi_fill) + TOTAL_W'(lo_fill);
    assign resp.not_empty   = (hi_fill != '0) || (lo_fill != '0);
    assign resp.head_data   = (hi_fill != '0) ? hi_head :
                              (lo_fill != '0) ? lo_head : '0;
    assign resp.tail_data   = (lo_fill != '0) ? lo_tail :
                              (hi_fill != '0) ? hi_tail : '0;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (hi_fill <= COUNT_W'(QUEUE_DEPTH)) && (lo_fill <= COUNT_W'(QUEUE_DEPTH)))
        else $error("queue fill above depth");

    a_push_high: assert property (@(posedge clk) disable iff (!rst_n)
        step && hi_ctrl.push |=> hi_fill == $past(hi_fill) + 1'b1)
        else $error("high push did not advance fill");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && err_next |=> $stable(hi_fill) && $stable(lo_fill))
        else $error("refused request changed queue state");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && hi_ctrl.clear |=> hi_fill == '0 && lo_fill == '0 && !resp.not_empty)
        else $error("clear left entries");

    a_result_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> resp.valid)
        else $error("request processed without result");

endmodule
